### rtl/lcrk_pkg.sv
// shared types, constants and saturation helpers for the liu-chen rk2 step block
`timescale 1ns / 1ps
`default_nettype none

package lcrk_pkg;

  // number format
  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 24;
  localparam int PROD_W     = 2 * WORD_WIDTH;
  localparam int COEF_W     = 31;
  localparam int DT_W       = 25;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 5;

  localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  // register reset values
  localparam logic [COEF_W-1:0] COEF_A_RST    = COEF_W'(167772160);
  localparam logic [COEF_W-1:0] COEF_B_RST    = COEF_W'(671088640);
  localparam logic [COEF_W-1:0] COEF_C_RST    = COEF_W'(41943040);
  localparam logic [DT_W-1:0]   TIME_STEP_RST = DT_W'(16777);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd3;

  // microprogram step addresses
  localparam logic [STEP_W-1:0] PC_BR     = 5'd0;
  localparam logic [STEP_W-1:0] PC_DIFF   = 5'd1;
  localparam logic [STEP_W-1:0] PC_MUL_A  = 5'd2;
  localparam logic [STEP_W-1:0] PC_MUL_B  = 5'd3;
  localparam logic [STEP_W-1:0] PC_MUL_XZ = 5'd4;
  localparam logic [STEP_W-1:0] PC_MUL_XY = 5'd5;
  localparam logic [STEP_W-1:0] PC_MUL_C  = 5'd6;
  localparam logic [STEP_W-1:0] PC_DZ     = 5'd7;
  localparam logic [STEP_W-1:0] PC_MID0   = 5'd8;
  localparam logic [STEP_W-1:0] PC_MID_X  = 5'd9;
  localparam logic [STEP_W-1:0] PC_MID_Y  = 5'd10;
  localparam logic [STEP_W-1:0] PC_MID_Z  = 5'd11;
  localparam logic [STEP_W-1:0] PC_FIN0   = 5'd12;
  localparam logic [STEP_W-1:0] PC_FIN_X  = 5'd13;
  localparam logic [STEP_W-1:0] PC_FIN_Y  = 5'd14;
  localparam logic [STEP_W-1:0] PC_FIN_Z  = 5'd15;
  localparam logic [STEP_W-1:0] PC_DONE   = 5'd16;
  localparam logic [STEP_W-1:0] PC_LOAD   = 5'd17;

  // operand sources; the p* sources follow the phase (point or midpoint)
  typedef enum logic [4:0] {
    SRC_X, SRC_Y, SRC_Z, SRC_XM, SRC_YM, SRC_ZM,
    SRC_PX, SRC_PY, SRC_PZ, SRC_DX, SRC_DY, SRC_DZ,
    SRC_T, SRC_A, SRC_B, SRC_C, SRC_DT
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_X, DST_Y, DST_Z, DST_XM, DST_YM, DST_ZM,
    DST_DX, DST_DY, DST_DZ, DST_T
  } dst_t;

  // writeback operations on the previous product and register operands
  typedef enum logic [2:0] {
    WB_NOP, WB_SUB, WB_MSAT, WB_MSUB, WB_MHADD, WB_MADD, WB_LOAD
  } wb_op_t;

  typedef enum logic [2:0] {
    SEQ_NEXT, SEQ_JMP, SEQ_JMP_FUNC, SEQ_JMP_PHASE, SEQ_JMP_SETPH, SEQ_DONE
  } seq_op_t;

  // one control word
  typedef struct packed {
    logic              mul_en;
    src_t              mul_a;
    src_t              mul_b;
    wb_op_t            op;
    src_t              wb_a;
    src_t              wb_b;
    dst_t              dst;
    seq_op_t           seq;
    logic [STEP_W-1:0] target;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{mul_en: 1'b0, mul_a: SRC_X, mul_b: SRC_X, op: WB_NOP,
                               wb_a: SRC_X, wb_b: SRC_X, dst: DST_NONE,
                               seq: SEQ_NEXT, target: PC_BR};

  // sequencer to datapath
  typedef struct packed {
    ctl_t ctl;
    logic phase;
    logic start;
    logic capture;
  } dp_cmd_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_a;
    logic [COEF_W-1:0] coef_b;
    logic [COEF_W-1:0] coef_c;
    logic [DT_W-1:0]   time_step;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] v;
    logic                         clip;
  } sat_t;

  // clamp a sum one bit wider than the word
  function automatic sat_t sat_sum(input logic signed [WORD_WIDTH:0] s);
    sat_t r;
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
      r.v    = s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
      r.clip = 1'b1;
    end else begin
      r.v    = s[WORD_WIDTH-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // drop the fraction bits of a full product (floor) and clamp
  function automatic sat_t mul_sat(input logic signed [PROD_W-1:0] p);
    sat_t r;
    logic [PROD_W-FRAC_BITS-WORD_WIDTH:0] top;
    top = p[PROD_W-1:FRAC_BITS+WORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      r.v    = p[FRAC_BITS+WORD_WIDTH-1:FRAC_BITS];
      r.clip = 1'b0;
    end else begin
      r.v    = p[PROD_W-1] ? WORD_MIN : WORD_MAX;
      r.clip = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/liu_chen_rk2_step.sv
// top level: configuration registers and the microcoded rk2 step engine
//
// Usage: the block holds a 3D point (signed Q8.24). Each input beat on
// in_valid/in_ready either advances the point one midpoint rk2 step of the
// Liu-Chen system (in_func = 0) or loads in_load_x/y/z (in_func = 1). Every
// beat yields one output beat on out_valid/out_ready with the point after it
// and a flag that is set if any intermediate value clipped.
// A new beat is taken only when the previous one has finished its microprogram
// (derivatives at the point, half step to the midpoint, derivatives there, full
// step; or, for a load, the copy of the latched point), with every multiply
// through one shared 32x32 multiplier.
// The output register holds a finished beat while out_ready is low; the next
// item is taken meanwhile and waits on its last step until that beat leaves.
// Reset (rst_n low, synchronous) clears the point to zero, restores the
// default coefficients and empties the output register.
// Configuration writes (cfg_we) are taken at any edge but are meant for
// idle periods.
`timescale 1ns / 1ps
`default_nettype none

module liu_chen_rk2_step (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_func,
  input  wire logic signed [lcrk_pkg::WORD_WIDTH-1:0] in_load_x,
  input  wire logic signed [lcrk_pkg::WORD_WIDTH-1:0] in_load_y,
  input  wire logic signed [lcrk_pkg::WORD_WIDTH-1:0] in_load_z,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [lcrk_pkg::WORD_WIDTH-1:0]      out_pos_x_out,
  output logic signed [lcrk_pkg::WORD_WIDTH-1:0]      out_pos_y_out,
  output logic signed [lcrk_pkg::WORD_WIDTH-1:0]      out_pos_z_out,
  output logic                                        out_saturated,
  input  wire logic                                   cfg_we,
  input  wire logic [lcrk_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [lcrk_pkg::COEF_W-1:0]            cfg_wdata
);

  lcrk_pkg::cfg_t            cfg_r;
  lcrk_pkg::ctl_t            rom_word;
  lcrk_pkg::dp_cmd_t         cmd;
  logic [lcrk_pkg::STEP_W-1:0] rom_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_a    <= lcrk_pkg::COEF_A_RST;
      cfg_r.coef_b    <= lcrk_pkg::COEF_B_RST;
      cfg_r.coef_c    <= lcrk_pkg::COEF_C_RST;
      cfg_r.time_step <= lcrk_pkg::TIME_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcrk_pkg::REG_COEF_A:    cfg_r.coef_a    <= cfg_wdata;
        lcrk_pkg::REG_COEF_B:    cfg_r.coef_b    <= cfg_wdata;
        lcrk_pkg::REG_COEF_C:    cfg_r.coef_c    <= cfg_wdata;
        lcrk_pkg::REG_TIME_STEP: cfg_r.time_step <= cfg_wdata[lcrk_pkg::DT_W-1:0];
        default: ;
      endcase
    end
  end

  // control store
  lcrk_ucode_rom u_rom (
    .addr (rom_addr),
    .word (rom_word)
  );

  // step counter and handshake
  lcrk_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rom_addr  (rom_addr),
    .rom_word  (rom_word),
    .cmd       (cmd)
  );

  // arithmetic
  lcrk_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_load_x (in_load_x),
    .in_load_y (in_load_y),
    .in_load_z (in_load_z),
    .out_x     (out_pos_x_out),
    .out_y     (out_pos_y_out),
    .out_z     (out_pos_z_out),
    .out_sat   (out_saturated)
  );

endmodule

`default_nettype wire

### rtl/lcrk_ucode_rom.sv
// control store: one control word per microprogram step
`timescale 1ns / 1ps
`default_nettype none

module lcrk_ucode_rom (
  input  wire logic [lcrk_pkg::STEP_W-1:0] addr,
  output lcrk_pkg::ctl_t                   word
);

  function automatic lcrk_pkg::ctl_t mk(
    input logic               mul_en,
    input lcrk_pkg::src_t     mul_a,
    input lcrk_pkg::src_t     mul_b,
    input lcrk_pkg::wb_op_t   op,
    input lcrk_pkg::src_t     wb_a,
    input lcrk_pkg::src_t     wb_b,
    input lcrk_pkg::dst_t     dst,
    input lcrk_pkg::seq_op_t  seq,
    input logic [lcrk_pkg::STEP_W-1:0] target
  );
    lcrk_pkg::ctl_t c;
    c.mul_en = mul_en;
    c.mul_a  = mul_a;
    c.mul_b  = mul_b;
    c.op     = op;
    c.wb_a   = wb_a;
    c.wb_b   = wb_b;
    c.dst    = dst;
    c.seq    = seq;
    c.target = target;
    return c;
  endfunction

  // program: derivatives (twice, point then midpoint), half step, full step
  always_comb begin
    case (addr)
      // load items branch off
      lcrk_pkg::PC_BR: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_NOP, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_NONE,
          lcrk_pkg::SEQ_JMP_FUNC, lcrk_pkg::PC_LOAD);
      // t = y - x
      lcrk_pkg::PC_DIFF: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_SUB, lcrk_pkg::SRC_PY, lcrk_pkg::SRC_PX, lcrk_pkg::DST_T,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      // a * t
      lcrk_pkg::PC_MUL_A: word = mk(1'b1, lcrk_pkg::SRC_A, lcrk_pkg::SRC_T,
          lcrk_pkg::WB_NOP, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_NONE,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      // b * x, dx = a * t
      lcrk_pkg::PC_MUL_B: word = mk(1'b1, lcrk_pkg::SRC_B, lcrk_pkg::SRC_PX,
          lcrk_pkg::WB_MSAT, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_DX,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      // x * z, t = b * x
      lcrk_pkg::PC_MUL_XZ: word = mk(1'b1, lcrk_pkg::SRC_PX, lcrk_pkg::SRC_PZ,
          lcrk_pkg::WB_MSAT, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_T,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      // x * y, dy = t - x * z
      lcrk_pkg::PC_MUL_XY: word = mk(1'b1, lcrk_pkg::SRC_PX, lcrk_pkg::SRC_PY,
          lcrk_pkg::WB_MSUB, lcrk_pkg::SRC_T, lcrk_pkg::SRC_X, lcrk_pkg::DST_DY,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      // c * z, t = x * y
      lcrk_pkg::PC_MUL_C: word = mk(1'b1, lcrk_pkg::SRC_C, lcrk_pkg::SRC_PZ,
          lcrk_pkg::WB_MSAT, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_T,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      // dz = t - c * z; second pass goes on to the full step
      lcrk_pkg::PC_DZ: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_MSUB, lcrk_pkg::SRC_T, lcrk_pkg::SRC_X, lcrk_pkg::DST_DZ,
          lcrk_pkg::SEQ_JMP_PHASE, lcrk_pkg::PC_FIN0);
      // midpoint
      lcrk_pkg::PC_MID0: word = mk(1'b1, lcrk_pkg::SRC_DX, lcrk_pkg::SRC_DT,
          lcrk_pkg::WB_NOP, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_NONE,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      lcrk_pkg::PC_MID_X: word = mk(1'b1, lcrk_pkg::SRC_DY, lcrk_pkg::SRC_DT,
          lcrk_pkg::WB_MHADD, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_XM,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      lcrk_pkg::PC_MID_Y: word = mk(1'b1, lcrk_pkg::SRC_DZ, lcrk_pkg::SRC_DT,
          lcrk_pkg::WB_MHADD, lcrk_pkg::SRC_Y, lcrk_pkg::SRC_X, lcrk_pkg::DST_YM,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      lcrk_pkg::PC_MID_Z: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_MHADD, lcrk_pkg::SRC_Z, lcrk_pkg::SRC_X, lcrk_pkg::DST_ZM,
          lcrk_pkg::SEQ_JMP_SETPH, lcrk_pkg::PC_DIFF);
      // full step
      lcrk_pkg::PC_FIN0: word = mk(1'b1, lcrk_pkg::SRC_DX, lcrk_pkg::SRC_DT,
          lcrk_pkg::WB_NOP, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_NONE,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      lcrk_pkg::PC_FIN_X: word = mk(1'b1, lcrk_pkg::SRC_DY, lcrk_pkg::SRC_DT,
          lcrk_pkg::WB_MADD, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_X,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      lcrk_pkg::PC_FIN_Y: word = mk(1'b1, lcrk_pkg::SRC_DZ, lcrk_pkg::SRC_DT,
          lcrk_pkg::WB_MADD, lcrk_pkg::SRC_Y, lcrk_pkg::SRC_X, lcrk_pkg::DST_Y,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      lcrk_pkg::PC_FIN_Z: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_MADD, lcrk_pkg::SRC_Z, lcrk_pkg::SRC_X, lcrk_pkg::DST_Z,
          lcrk_pkg::SEQ_NEXT, lcrk_pkg::PC_BR);
      // hand the result over
      lcrk_pkg::PC_DONE: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_NOP, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_NONE,
          lcrk_pkg::SEQ_DONE, lcrk_pkg::PC_BR);
      // load the given point
      lcrk_pkg::PC_LOAD: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_LOAD, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_NONE,
          lcrk_pkg::SEQ_JMP, lcrk_pkg::PC_DONE);
      default: word = mk(1'b0, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X,
          lcrk_pkg::WB_NOP, lcrk_pkg::SRC_X, lcrk_pkg::SRC_X, lcrk_pkg::DST_NONE,
          lcrk_pkg::SEQ_DONE, lcrk_pkg::PC_BR);
    endcase
  end

endmodule

`default_nettype wire

### rtl/lcrk_datapath.sv
// register file, shared multiplier and saturating writeback unit
`timescale 1ns / 1ps
`default_nettype none

module lcrk_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire lcrk_pkg::dp_cmd_t                     cmd,
  input  wire lcrk_pkg::cfg_t                        cfg,
  input  wire logic signed [lcrk_pkg::WORD_WIDTH-1:0] in_load_x,
  input  wire logic signed [lcrk_pkg::WORD_WIDTH-1:0] in_load_y,
  input  wire logic signed [lcrk_pkg::WORD_WIDTH-1:0] in_load_z,
  output logic signed [lcrk_pkg::WORD_WIDTH-1:0]      out_x,
  output logic signed [lcrk_pkg::WORD_WIDTH-1:0]      out_y,
  output logic signed [lcrk_pkg::WORD_WIDTH-1:0]      out_z,
  output logic                                        out_sat
);

  localparam int W = lcrk_pkg::WORD_WIDTH;

  logic signed [W-1:0] x_r, y_r, z_r, xm_r, ym_r, zm_r;
  logic signed [W-1:0] dx_r, dy_r, dz_r, t_r;
  logic signed [W-1:0] lx_r, ly_r, lz_r;
  logic signed [W-1:0] ox_r, oy_r, oz_r;
  logic                clip_r, osat_r;
  logic signed [lcrk_pkg::PROD_W-1:0] p_r;

  logic signed [W-1:0] ma, mb, wa, wbv, half_v;
  logic signed [W:0]   sum;
  lcrk_pkg::sat_t      ms, res;
  logic                wb_clip;

  // operand select
  function automatic logic signed [W-1:0] pick(input lcrk_pkg::src_t s);
    logic signed [W-1:0] v;
    case (s)
      lcrk_pkg::SRC_X:  v = x_r;
      lcrk_pkg::SRC_Y:  v = y_r;
      lcrk_pkg::SRC_Z:  v = z_r;
      lcrk_pkg::SRC_XM: v = xm_r;
      lcrk_pkg::SRC_YM: v = ym_r;
      lcrk_pkg::SRC_ZM: v = zm_r;
      lcrk_pkg::SRC_PX: v = cmd.phase ? xm_r : x_r;
      lcrk_pkg::SRC_PY: v = cmd.phase ? ym_r : y_r;
      lcrk_pkg::SRC_PZ: v = cmd.phase ? zm_r : z_r;
      lcrk_pkg::SRC_DX: v = dx_r;
      lcrk_pkg::SRC_DY: v = dy_r;
      lcrk_pkg::SRC_DZ: v = dz_r;
      lcrk_pkg::SRC_T:  v = t_r;
      lcrk_pkg::SRC_A:  v = {{(W-lcrk_pkg::COEF_W){1'b0}}, cfg.coef_a};
      lcrk_pkg::SRC_B:  v = {{(W-lcrk_pkg::COEF_W){1'b0}}, cfg.coef_b};
      lcrk_pkg::SRC_C:  v = {{(W-lcrk_pkg::COEF_W){1'b0}}, cfg.coef_c};
      lcrk_pkg::SRC_DT: v = {{(W-lcrk_pkg::DT_W){1'b0}}, cfg.time_step};
      default:          v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    ma  = pick(cmd.ctl.mul_a);
    mb  = pick(cmd.ctl.mul_b);
    wa  = pick(cmd.ctl.wb_a);
    wbv = pick(cmd.ctl.wb_b);
  end

  // writeback: saturate the previous product and combine with a register, or subtract two registers
  always_comb begin
    ms      = lcrk_pkg::mul_sat(p_r);
    half_v  = {ms.v[W-1], ms.v[W-1:1]};
    sum     = '0;
    res     = ms;
    wb_clip = 1'b0;
    case (cmd.ctl.op)
      lcrk_pkg::WB_SUB: begin
        sum     = {wa[W-1], wa} - {wbv[W-1], wbv};
        res     = lcrk_pkg::sat_sum(sum);
        wb_clip = res.clip;
      end
      lcrk_pkg::WB_MSAT: begin
        wb_clip = ms.clip;
      end
      lcrk_pkg::WB_MSUB: begin
        sum     = {wa[W-1], wa} - {ms.v[W-1], ms.v};
        res     = lcrk_pkg::sat_sum(sum);
        wb_clip = res.clip | ms.clip;
      end
      lcrk_pkg::WB_MHADD: begin
        sum     = {wa[W-1], wa} + {half_v[W-1], half_v};
        res     = lcrk_pkg::sat_sum(sum);
        wb_clip = res.clip | ms.clip;
      end
      lcrk_pkg::WB_MADD: begin
        sum     = {wa[W-1], wa} + {ms.v[W-1], ms.v};
        res     = lcrk_pkg::sat_sum(sum);
        wb_clip = res.clip | ms.clip;
      end
      default: begin
        wb_clip = 1'b0;
      end
    endcase
  end

  // point registers, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else if (cmd.ctl.op == lcrk_pkg::WB_LOAD) begin
      x_r <= lx_r;
      y_r <= ly_r;
      z_r <= lz_r;
    end else if (cmd.ctl.op != lcrk_pkg::WB_NOP) begin
      case (cmd.ctl.dst)
        lcrk_pkg::DST_X: x_r <= res.v;
        lcrk_pkg::DST_Y: y_r <= res.v;
        lcrk_pkg::DST_Z: z_r <= res.v;
        default: ;
      endcase
    end
  end

  // scratch registers, product and load latch
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lx_r <= in_load_x;
      ly_r <= in_load_y;
      lz_r <= in_load_z;
    end
    if (cmd.ctl.mul_en) begin
      p_r <= ma * mb;
    end
    if (cmd.ctl.op != lcrk_pkg::WB_NOP && cmd.ctl.op != lcrk_pkg::WB_LOAD) begin
      case (cmd.ctl.dst)
        lcrk_pkg::DST_XM: xm_r <= res.v;
        lcrk_pkg::DST_YM: ym_r <= res.v;
        lcrk_pkg::DST_ZM: zm_r <= res.v;
        lcrk_pkg::DST_DX: dx_r <= res.v;
        lcrk_pkg::DST_DY: dy_r <= res.v;
        lcrk_pkg::DST_DZ: dz_r <= res.v;
        lcrk_pkg::DST_T:  t_r  <= res.v;
        default: ;
      endcase
    end
  end

  // clip flag for the current item
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      clip_r <= 1'b0;
    end else if (wb_clip) begin
      clip_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ox_r   <= x_r;
      oy_r   <= y_r;
      oz_r   <= z_r;
      osat_r <= clip_r;
    end
  end

  assign out_x   = ox_r;
  assign out_y   = oy_r;
  assign out_z   = oz_r;
  assign out_sat = osat_r;

endmodule

`default_nettype wire

### rtl/lcrk_sequencer.sv
// step counter, jumps and channel handshake
`timescale 1ns / 1ps
`default_nettype none

module lcrk_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lcrk_pkg::STEP_W-1:0]        rom_addr,
  input  wire lcrk_pkg::ctl_t                rom_word,
  output lcrk_pkg::dp_cmd_t                  cmd
);

  logic                        busy_r, busy_nxt;
  logic [lcrk_pkg::STEP_W-1:0] pc_r, pc_nxt, pc_inc;
  logic                        phase_r, phase_nxt;
  logic                        func_r, func_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        start, capture;

  assign pc_inc   = pc_r + lcrk_pkg::STEP_W'(1);
  assign in_ready = !busy_r;
  assign rom_addr = pc_r;
  assign out_valid = out_valid_r;

  // next step and handshake
  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    phase_nxt     = phase_r;
    func_nxt      = func_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    capture       = 1'b0;
    start         = in_valid & ~busy_r;
    if (start) begin
      busy_nxt  = 1'b1;
      pc_nxt    = lcrk_pkg::PC_BR;
      phase_nxt = 1'b0;
      func_nxt  = in_func;
    end else if (busy_r) begin
      case (rom_word.seq)
        lcrk_pkg::SEQ_NEXT:      pc_nxt = pc_inc;
        lcrk_pkg::SEQ_JMP:       pc_nxt = rom_word.target;
        lcrk_pkg::SEQ_JMP_FUNC:  pc_nxt = func_r ? rom_word.target : pc_inc;
        lcrk_pkg::SEQ_JMP_PHASE: pc_nxt = phase_r ? rom_word.target : pc_inc;
        lcrk_pkg::SEQ_JMP_SETPH: begin
          pc_nxt    = rom_word.target;
          phase_nxt = 1'b1;
        end
        lcrk_pkg::SEQ_DONE: begin
          // wait here while the previous beat is still unclaimed
          if (!out_valid_r || out_ready) begin
            capture       = 1'b1;
            out_valid_nxt = 1'b1;
            busy_nxt      = 1'b0;
            phase_nxt     = 1'b0;
          end
        end
        default: pc_nxt = pc_inc;
      endcase
    end
  end

  // datapath command; idle cycles issue no work
  always_comb begin
    cmd.ctl     = busy_r ? rom_word : lcrk_pkg::CTL_NOP;
    cmd.phase   = phase_r;
    cmd.start   = start;
    cmd.capture = capture;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= lcrk_pkg::PC_BR;
      phase_r     <= 1'b0;
      func_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      func_r      <= func_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_start_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (busy_r && pc_r == lcrk_pkg::PC_BR))
    else $error("accepted beat did not start the program");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= lcrk_pkg::PC_LOAD))
    else $error("step counter left the program");

  a_phase_busy: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> busy_r)
    else $error("midpoint phase set while idle");

  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    capture |-> (!out_valid_r || out_ready))
    else $error("result overwrote an unclaimed beat");
`endif

endmodule

`default_nettype wire

### test/tb_liu_chen_rk2_step.sv
// self-checking testbench for the liu-chen rk2 step block: directed vectors, then random phases
`timescale 1ns / 1ps

module tb_liu_chen_rk2_step;

  // number format of the block
  localparam int WORD_WIDTH = lcrk_pkg::WORD_WIDTH;
  localparam int FRAC_BITS  = lcrk_pkg::FRAC_BITS;
  localparam int CFG_IDX_W  = lcrk_pkg::CFG_IDX_W;
  localparam int COEF_W     = lcrk_pkg::COEF_W;
  localparam int DT_W       = lcrk_pkg::DT_W;
  localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = lcrk_pkg::WORD_MAX;
  localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = lcrk_pkg::WORD_MIN;

  localparam int HALF_PERIOD     = 5;
  localparam int RUN_LIMIT       = 600000;
  localparam int SETTLE_CYCLES   = 30;
  localparam int PHASE_COUNT     = 8;
  localparam int BEATS_PER_PHASE = 154;
  localparam int PRINT_CAP       = 40;
  localparam int DIRECTED_ROWS   = 22;

  localparam logic FUNC_STEP = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  localparam logic signed [WORD_WIDTH-1:0] Q_ONE = 1 <<< FRAC_BITS;
  localparam logic signed [WORD_WIDTH-1:0] ALT_A = 32'sh5555_5555;
  localparam logic signed [WORD_WIDTH-1:0] ALT_B = 32'shAAAA_AAAA;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0] x;
    logic signed [WORD_WIDTH-1:0] y;
    logic signed [WORD_WIDTH-1:0] z;
  } vec3_t;

  typedef struct packed {
    vec3_t pos;
    logic  sat;
  } point_beat_t;

  // one directed vector; want is used only where typed is set
  typedef struct packed {
    logic        func;
    vec3_t       load;
    logic        typed;
    point_beat_t want;
  } vector_row_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_func;
  logic signed [WORD_WIDTH-1:0] in_load_x;
  logic signed [WORD_WIDTH-1:0] in_load_y;
  logic signed [WORD_WIDTH-1:0] in_load_z;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [WORD_WIDTH-1:0] out_pos_x_out;
  logic signed [WORD_WIDTH-1:0] out_pos_y_out;
  logic signed [WORD_WIDTH-1:0] out_pos_z_out;
  logic                         out_saturated;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [COEF_W-1:0]            cfg_wdata;

  // predictor state: registers and point as the block should hold them
  lcrk_pkg::cfg_t cfg_now;
  vec3_t       point_now;
  logic        clip_flag;
  point_beat_t expected_points[$];

  int          mismatch_count;
  int          results_seen;
  int          cycle_count;
  int          sender_idle_pct;
  int          stall_pct;
  point_beat_t want_now;

  vector_row_t directed_rows [DIRECTED_ROWS] = '{
    '{FUNC_STEP, '0, 1'b1, '0},
    '{FUNC_LOAD, '{WORD_MAX, WORD_MAX, WORD_MAX}, 1'b1,
      '{'{WORD_MAX, WORD_MAX, WORD_MAX}, 1'b0}},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_LOAD, '{WORD_MIN, WORD_MIN, WORD_MIN}, 1'b1,
      '{'{WORD_MIN, WORD_MIN, WORD_MIN}, 1'b0}},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_LOAD, '{WORD_MAX, WORD_MIN, 0}, 1'b1, '{'{WORD_MAX, WORD_MIN, 0}, 1'b0}},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_LOAD, '{WORD_MIN, WORD_MAX, -1}, 1'b1, '{'{WORD_MIN, WORD_MAX, -1}, 1'b0}},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_LOAD, '{Q_ONE, Q_ONE, Q_ONE}, 1'b1, '{'{Q_ONE, Q_ONE, Q_ONE}, 1'b0}},
    '{FUNC_STEP, '{ALT_A, ALT_A, ALT_A}, 1'b0, '0},
    '{FUNC_STEP, '{ALT_B, ALT_B, ALT_B}, 1'b0, '0},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_LOAD, '{ALT_A, ALT_B, -Q_ONE}, 1'b1, '{'{ALT_A, ALT_B, -Q_ONE}, 1'b0}},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_LOAD, '0, 1'b1, '0},
    '{FUNC_STEP, '0, 1'b1, '0},
    '{FUNC_LOAD, '{Q_ONE, -(Q_ONE <<< 1), Q_ONE <<< 4}, 1'b1,
      '{'{Q_ONE, -(Q_ONE <<< 1), Q_ONE <<< 4}, 1'b0}},
    '{FUNC_STEP, '{-1, -1, -1}, 1'b0, '0},
    '{FUNC_STEP, '0, 1'b0, '0},
    '{FUNC_STEP, '0, 1'b0, '0}
  };

  liu_chen_rk2_step DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_func      (in_func),
    .in_load_x    (in_load_x),
    .in_load_y    (in_load_y),
    .in_load_z    (in_load_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_pos_x_out(out_pos_x_out),
    .out_pos_y_out(out_pos_y_out),
    .out_pos_z_out(out_pos_z_out),
    .out_saturated(out_saturated),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // fixed-point arithmetic of the predictor; any clip raises clip_flag
  function automatic logic signed [WORD_WIDTH-1:0] clamp_word(input longint v);
    if (v > longint'(WORD_MAX)) begin
      clip_flag = 1'b1;
      return WORD_MAX;
    end
    if (v < longint'(WORD_MIN)) begin
      clip_flag = 1'b1;
      return WORD_MIN;
    end
    return v[WORD_WIDTH-1:0];
  endfunction

  function automatic logic signed [WORD_WIDTH-1:0] fx_add(
    input logic signed [WORD_WIDTH-1:0] a, input logic signed [WORD_WIDTH-1:0] b);
    return clamp_word(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [WORD_WIDTH-1:0] fx_sub(
    input logic signed [WORD_WIDTH-1:0] a, input logic signed [WORD_WIDTH-1:0] b);
    return clamp_word(longint'(a) - longint'(b));
  endfunction

  // full product, floor of the fraction bits, then clamp
  function automatic logic signed [WORD_WIDTH-1:0] fx_mul(
    input logic signed [WORD_WIDTH-1:0] a, input logic signed [WORD_WIDTH-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp_word(p >>> FRAC_BITS);
  endfunction

  // liu-chen derivatives at a point
  function automatic vec3_t lc_rates(input vec3_t p);
    vec3_t d;
    d.x = fx_mul(cfg_now.coef_a, fx_sub(p.y, p.x));
    d.y = fx_sub(fx_mul(cfg_now.coef_b, p.x), fx_mul(p.x, p.z));
    d.z = fx_sub(fx_mul(p.x, p.y), fx_mul(cfg_now.coef_c, p.z));
    return d;
  endfunction

  // one beat: load the point or make one midpoint step, return the point after it
  function automatic point_beat_t rk2_advance(input logic func, input vec3_t load);
    vec3_t                        d1;
    vec3_t                        mid;
    vec3_t                        d2;
    logic signed [WORD_WIDTH-1:0] inc;
    logic signed [WORD_WIDTH-1:0] dt;
    point_beat_t                  r;
    clip_flag = 1'b0;
    dt = cfg_now.time_step;
    if (func == FUNC_LOAD) begin
      point_now = load;
    end else begin
      d1 = lc_rates(point_now);
      inc = fx_mul(d1.x, dt);
      mid.x = fx_add(point_now.x, inc >>> 1);
      inc = fx_mul(d1.y, dt);
      mid.y = fx_add(point_now.y, inc >>> 1);
      inc = fx_mul(d1.z, dt);
      mid.z = fx_add(point_now.z, inc >>> 1);
      d2 = lc_rates(mid);
      point_now.x = fx_add(point_now.x, fx_mul(d2.x, dt));
      point_now.y = fx_add(point_now.y, fx_mul(d2.y, dt));
      point_now.z = fx_add(point_now.z, fx_mul(d2.z, dt));
    end
    r.pos = point_now;
    r.sat = clip_flag;
    return r;
  endfunction

  function automatic logic signed [WORD_WIDTH-1:0] random_coord();
    logic signed [WORD_WIDTH-1:0] v;
    v = $urandom;
    return v >>> $urandom_range(0, 8);
  endfunction

  function automatic vec3_t noise_vec();
    vec3_t v;
    v.x = $urandom;
    v.y = $urandom;
    v.z = $urandom;
    return v;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic set_idle(input idle_mode_e mode);
    sender_idle_pct = (mode == IDLE_SENDER) ? 82 : (mode == IDLE_BOTH) ? 9 : 0;
    stall_pct       = (mode == IDLE_RECEIVER) ? 82 : (mode == IDLE_BOTH) ? 9 : 0;
  endtask

  // present one beat from a falling edge, hold it until taken, return at the next falling edge
  task automatic send_beat(input logic func, input vec3_t load, input logic typed,
                           input point_beat_t typed_want);
    point_beat_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_load_x <= load.x;
    in_load_y <= load.y;
    in_load_z <= load.z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = rk2_advance(func, load);
    expected_points.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // sender holds off until every result is back
  task automatic hold_until_drained();
    if (expected_points.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_points.size() != 0) @(negedge clk);
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_points.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      lcrk_pkg::REG_COEF_A:    cfg_now.coef_a = data;
      lcrk_pkg::REG_COEF_B:    cfg_now.coef_b = data;
      lcrk_pkg::REG_COEF_C:    cfg_now.coef_c = data;
      lcrk_pkg::REG_TIME_STEP: cfg_now.time_step = data[DT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // random phase: mostly a load followed by a run of steps, some loose beats
  task automatic run_random_beats(input int quota);
    int    sent;
    int    run_len;
    vec3_t pt;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(39) == 0) hold_until_drained();
      if ($urandom_range(99) < 85) begin
        pt.x = random_coord();
        pt.y = random_coord();
        pt.z = random_coord();
        send_beat(FUNC_LOAD, pt, 1'b0, '0);
        run_len = $urandom_range(1, 12);
        repeat (run_len) send_beat(FUNC_STEP, noise_vec(), 1'b0, '0);
        sent += run_len + 1;
      end else begin
        send_beat(logic'($urandom_range(1)), noise_vec(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // result side: random stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare every result beat with the oldest expected point
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        flag_mismatch($sformatf("beat %0d arrived with nothing expected", results_seen));
      end else begin
        want_now = expected_points.pop_front();
        if (out_pos_x_out !== want_now.pos.x)
          flag_mismatch($sformatf("beat %0d x got %h want %h", results_seen,
                                  out_pos_x_out, want_now.pos.x));
        if (out_pos_y_out !== want_now.pos.y)
          flag_mismatch($sformatf("beat %0d y got %h want %h", results_seen,
                                  out_pos_y_out, want_now.pos.y));
        if (out_pos_z_out !== want_now.pos.z)
          flag_mismatch($sformatf("beat %0d z got %h want %h", results_seen,
                                  out_pos_z_out, want_now.pos.z));
        if (out_saturated !== want_now.sat)
          flag_mismatch($sformatf("beat %0d saturated got %b want %b", results_seen,
                                  out_saturated, want_now.sat));
      end
      results_seen++;
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("tb_liu_chen_rk2_step: FAIL");
      $finish;
    end
  end

  initial begin
    logic [COEF_W-1:0] a_val;
    logic [COEF_W-1:0] b_val;
    logic [COEF_W-1:0] c_val;
    logic [DT_W-1:0]   dt_val;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_STEP;
    in_load_x       = '0;
    in_load_y       = '0;
    in_load_z       = '0;
    out_ready       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = lcrk_pkg::REG_COEF_A;
    cfg_wdata       = '0;
    mismatch_count  = 0;
    results_seen    = 0;
    cycle_count     = 0;
    cfg_now         = '{coef_a: lcrk_pkg::COEF_A_RST, coef_b: lcrk_pkg::COEF_B_RST,
                        coef_c: lcrk_pkg::COEF_C_RST, time_step: lcrk_pkg::TIME_STEP_RST};
    point_now       = '0;
    set_idle(IDLE_NONE);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed vectors at the reset coefficients
    foreach (directed_rows[i])
      send_beat(directed_rows[i].func, directed_rows[i].load, directed_rows[i].typed,
                directed_rows[i].want);
    quiesce();

    // random phases, each with its own register setting and idling pattern
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          a_val = lcrk_pkg::COEF_A_RST; b_val = lcrk_pkg::COEF_B_RST;
          c_val = lcrk_pkg::COEF_C_RST; dt_val = lcrk_pkg::TIME_STEP_RST;
        end
        1: begin
          a_val = COEF_W'($urandom_range(0, 16 << FRAC_BITS));
          b_val = COEF_W'($urandom_range(0, 64 << FRAC_BITS));
          c_val = COEF_W'($urandom_range(0, 8 << FRAC_BITS));
          dt_val = DT_W'($urandom_range(0, 1 << 16));
        end
        // largest coefficients, time step above 1.0
        2: begin
          a_val = '1; b_val = '1; c_val = '1; dt_val = '1;
        end
        3: begin
          a_val = '0; b_val = '0; c_val = '0; dt_val = '0;
        end
        4: begin
          a_val = lcrk_pkg::COEF_A_RST; b_val = lcrk_pkg::COEF_B_RST;
          c_val = lcrk_pkg::COEF_C_RST; dt_val = DT_W'(1 << FRAC_BITS);
        end
        5: begin
          a_val = COEF_W'($urandom); b_val = COEF_W'($urandom); c_val = COEF_W'($urandom);
          dt_val = DT_W'($urandom);
        end
        6: begin
          a_val = lcrk_pkg::COEF_A_RST; b_val = '1; c_val = '0; dt_val = DT_W'(1);
        end
        default: begin
          a_val = lcrk_pkg::COEF_A_RST; b_val = lcrk_pkg::COEF_B_RST;
          c_val = lcrk_pkg::COEF_C_RST;
          dt_val = DT_W'($urandom_range(1, 1 << 20));
        end
      endcase
      write_reg(lcrk_pkg::REG_COEF_A, a_val);
      write_reg(lcrk_pkg::REG_COEF_B, b_val);
      write_reg(lcrk_pkg::REG_COEF_C, c_val);
      write_reg(lcrk_pkg::REG_TIME_STEP, COEF_W'(dt_val));
      cfg_we <= 1'b0;
      set_idle(idle_mode_e'(phase % 4));
      run_random_beats(BEATS_PER_PHASE);
      quiesce();
    end

    if (mismatch_count == 0) begin
      $display("tb_liu_chen_rk2_step: PASS");
    end else begin
      $display("tb_liu_chen_rk2_step: FAIL");
    end
    $finish;
  end

endmodule
